// ----- rtl/core/itp_pkg.sv -----
// shared constants, widths and types for the iso-tp reassembler
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

    // largest message that is reassembled, in bytes
    localparam int MAX_MESSAGE = 512;

    // field widths
    localparam int ID_W   = 29;
    localparam int DLC_W  = 4;
    localparam int DATA_W = 64;
    localparam int LEN_W  = 12;
    localparam int BYTE_W = 8;
    localparam int SEQ_W  = 4;
    localparam int CNT_W  = 4;

    // byte lanes of the payload store
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // payload store geometry
    localparam int FILL_W = $clog2(MAX_MESSAGE + 1);
    localparam int ROWS   = (MAX_MESSAGE + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // packed stream widths
    localparam int S_TDATA_W = ((ID_W + DLC_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + LEN_W + DATA_W + CNT_W + 7) / 8) * 8;

    // frame type codes
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;

    // frame layout constants
    localparam logic [3:0]        SF_MAX_LEN = 4'd7;
    localparam logic [DLC_W-1:0]  FF_MIN_DLC = 4'd2;
    localparam logic [LANE_W-1:0] FF_BYTES   = 3'd6;
    localparam logic [LANE_W-1:0] CF_BYTES   = 3'd7;
    localparam logic [LANE_W-1:0] FF_FIRST   = 3'd2;
    localparam logic [LANE_W-1:0] CF_FIRST   = 3'd1;
    localparam logic [SEQ_W-1:0]  SEQ_START  = 4'd1;

    // write command broadcast to all byte lanes
    typedef struct packed {
        logic              active;
        logic [FILL_W-1:0] base;
        logic [LANE_W-1:0] count;
        logic [LANE_W-1:0] first;
    } itp_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/itp_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/itp_lane.sv -----
// one byte lane of the payload store: write select and lane ram
`timescale 1ns / 1ps
`default_nettype none

module itp_lane
    import itp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [LANE_W-1:0] lane_idx,
    input  wire itp_wr_t           wr,
    input  wire logic [DATA_W-1:0] frame_data,
    input  wire logic [ROW_W-1:0]  rd_row,
    output logic      [BYTE_W-1:0] rd_byte
);

    logic [LANE_W-1:0] offs;
    logic [LANE_W-1:0] src;
    logic [FILL_W-1:0] idx;
    logic              hit;
    logic [BYTE_W-1:0] wbyte;

    // which byte of the write run lands in this lane
    assign offs  = lane_idx - wr.base[LANE_W-1:0];
    assign hit   = wr.active && (offs < wr.count);
    assign idx   = wr.base + FILL_W'(offs);
    assign src   = wr.first + offs;
    assign wbyte = frame_data[src*BYTE_W +: BYTE_W];

    itp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk  (aclk),
        .we    (hit),
        .waddr (idx[LANE_W +: ROW_W]),
        .wdata (wbyte),
        .raddr (rd_row),
        .rdata (rd_byte)
    );

endmodule

`default_nettype wire

// ----- rtl/core/itp_merge.sv -----
// merges lane bytes or single-frame bytes into one masked chunk
`timescale 1ns / 1ps
`default_nettype none

module itp_merge
    import itp_pkg::*;
(
    input  wire logic                         sel_frame,
    input  wire logic [DATA_W-1:0]            frame_data,
    input  wire logic [LANES-1:0][BYTE_W-1:0] lane_bytes,
    input  wire logic [CNT_W-1:0]             count,
    output logic      [DATA_W-1:0]            chunk_data
);

    // pick the byte source per lane, zero the bytes past the count
    always_comb begin
        logic [BYTE_W-1:0] b;
        for (int l = 0; l < LANES; l++) begin
            if (sel_frame) begin
                b = (l < LANES - 1) ? frame_data[(l+1)*BYTE_W +: BYTE_W] : '0;
            end else begin
                b = lane_bytes[l];
            end
            chunk_data[l*BYTE_W +: BYTE_W] = (CNT_W'(l) < count) ? b : '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/isotp_reassembler_core.sv -----
// top level of the iso-tp reassembler: frame decode, state, lanes and chunk output
//
//  channel | direction | tdata (low bit up)                          | tuser | tlast
//  --------+-----------+---------------------------------------------+-------+-----------
//  s_      | in        | frame_id, frame_length, frame_data          | ext   | -
//  m_      | out       | msg_id, total_length, chunk_data, chunk_bytes| ext   | chunk_last
//
// a frame is accepted in ST_IDLE, then decoded in ST_EXEC with up to seven byte-lane writes at once
// a single frame passes through ST_SF to load its chunk into the output register
// a completed message streams chunk by chunk: ST_RDA covers the registered lane ram read, ST_RDB loads the chunk
// reset clears the sequencer, reassembly state and output valid only; the lane rams hold no reset value
// a stalled m_ side holds the chunk; s_tready is high only between frames
`timescale 1ns / 1ps
`default_nettype none

module isotp_reassembler_core
    import itp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // frame_id, frame_length, frame_data
    input  wire logic                 s_tuser,  // frame_extended
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // msg_id, total_length, chunk_data, chunk_bytes
    output logic                      m_tuser,  // msg_ext
    output logic                      m_tlast   // chunk_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SF   = 3'd2;
    localparam logic [2:0] ST_RDA  = 3'd3;
    localparam logic [2:0] ST_RDB  = 3'd4;

    logic [2:0]        state_reg, state_next;

    // captured frame
    logic [ID_W-1:0]   f_id_reg;
    logic              f_ext_reg;
    logic [DLC_W-1:0]  f_dlc_reg;
    logic [DATA_W-1:0] f_data_reg;

    // reassembly state
    logic [ID_W-1:0]   held_id_reg, held_id_next;
    logic              held_ext_reg, held_ext_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // message being emitted
    logic [ID_W-1:0]   emit_id_reg, emit_id_next;
    logic              emit_ext_reg, emit_ext_next;
    logic [LEN_W-1:0]  emit_len_reg, emit_len_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    // output register
    logic              m_valid_reg;
    logic [ID_W-1:0]   o_id_reg;
    logic              o_ext_reg;
    logic [LEN_W-1:0]  o_len_reg;
    logic [DATA_W-1:0] o_data_reg;
    logic [CNT_W-1:0]  o_cnt_reg;
    logic              o_last_reg;

    logic              s_accept;
    logic [3:0]        f_pci;
    logic [3:0]        f_nib;
    logic [LEN_W-1:0]  ff_len;
    logic [LANE_W-1:0] ff_cnt;
    logic [LEN_W-1:0]  cf_rem;
    logic [LANE_W-1:0] cf_cnt;
    logic [FILL_W-1:0] cf_fill;
    logic              cf_done;
    logic              cf_ok;
    logic              sf_ok;
    logic [LEN_W-1:0]  rd_rem;
    logic [CNT_W-1:0]  rd_cnt;
    logic              rd_last;
    logic [CNT_W-1:0]  out_cnt;
    logic              out_last;
    logic              out_free;
    logic              load_out;
    logic              clear_st;
    itp_wr_t           wr;

    logic [LANES-1:0][BYTE_W-1:0] lane_bytes;
    logic [DATA_W-1:0]            chunk;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // frame decode
    assign f_pci   = f_data_reg[7:4];
    assign f_nib   = f_data_reg[3:0];
    assign ff_len  = {f_nib, f_data_reg[15:8]};
    assign ff_cnt  = (ff_len > LEN_W'(FF_BYTES)) ? FF_BYTES : ff_len[LANE_W-1:0];
    assign cf_rem  = (exp_len_reg > LEN_W'(fill_reg)) ? exp_len_reg - LEN_W'(fill_reg) : '0;
    assign cf_cnt  = (cf_rem > LEN_W'(CF_BYTES)) ? CF_BYTES : cf_rem[LANE_W-1:0];
    assign cf_fill = fill_reg + FILL_W'(cf_cnt);
    assign cf_done = LEN_W'(cf_fill) >= exp_len_reg;
    assign cf_ok   = (fill_reg != '0) && (f_id_reg == held_id_reg) && (f_nib == next_seq_reg);
    assign sf_ok   = (f_nib <= SF_MAX_LEN) && (f_dlc_reg > f_nib);

    // chunk size and end of message during readout
    assign rd_rem  = emit_len_reg - LEN_W'({row_reg, {LANE_W{1'b0}}});
    assign rd_cnt  = (rd_rem > LEN_W'(LANES)) ? CNT_W'(LANES) : rd_rem[CNT_W-1:0];
    assign rd_last = (rd_rem <= LEN_W'(LANES));

    assign out_cnt  = (state_reg == ST_SF) ? emit_len_reg[CNT_W-1:0] : rd_cnt;
    assign out_last = (state_reg == ST_SF) ? 1'b1 : rd_last;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = out_free && ((state_reg == ST_SF) || (state_reg == ST_RDB));

    // sequencer and reassembly state update
    always_comb begin
        state_next    = state_reg;
        held_id_next  = held_id_reg;
        held_ext_next = held_ext_reg;
        exp_len_next  = exp_len_reg;
        next_seq_next = next_seq_reg;
        fill_next     = fill_reg;
        emit_id_next  = emit_id_reg;
        emit_ext_next = emit_ext_reg;
        emit_len_next = emit_len_reg;
        row_next      = row_reg;
        clear_st      = 1'b0;
        wr            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                if (f_dlc_reg != '0) begin
                    unique case (f_pci)
                        PCI_SF: begin
                            if (sf_ok) begin
                                emit_id_next  = f_id_reg;
                                emit_ext_next = f_ext_reg;
                                emit_len_next = LEN_W'(f_nib);
                                state_next    = ST_SF;
                            end
                        end
                        PCI_FF: begin
                            if ((f_dlc_reg < FF_MIN_DLC) || (ff_len > LEN_W'(MAX_MESSAGE))) begin
                                clear_st = 1'b1;
                            end else begin
                                held_id_next  = f_id_reg;
                                held_ext_next = f_ext_reg;
                                exp_len_next  = ff_len;
                                next_seq_next = SEQ_START;
                                fill_next     = FILL_W'(ff_cnt);
                                wr.active     = 1'b1;
                                wr.base       = '0;
                                wr.count      = ff_cnt;
                                wr.first      = FF_FIRST;
                            end
                        end
                        PCI_CF: begin
                            if (!cf_ok) begin
                                clear_st = 1'b1;
                            end else begin
                                wr.active = 1'b1;
                                wr.base   = fill_reg;
                                wr.count  = cf_cnt;
                                wr.first  = CF_FIRST;
                                if (cf_done) begin
                                    emit_id_next  = held_id_reg;
                                    emit_ext_next = held_ext_reg;
                                    emit_len_next = exp_len_reg;
                                    row_next      = '0;
                                    clear_st      = 1'b1;
                                    state_next    = ST_RDA;
                                end else begin
                                    next_seq_next = next_seq_reg + SEQ_W'(1);
                                    fill_next     = cf_fill;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SF: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RDA: begin
                state_next = ST_RDB;
            end
            ST_RDB: begin
                if (out_free) begin
                    if (rd_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next   = row_reg + ROW_W'(1);
                        state_next = ST_RDA;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_st) begin
            held_id_next  = '0;
            held_ext_next = 1'b0;
            exp_len_next  = '0;
            next_seq_next = SEQ_START;
            fill_next     = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_id_reg  <= '0;
            held_ext_reg <= 1'b0;
            exp_len_reg  <= '0;
            next_seq_reg <= SEQ_START;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_id_reg  <= held_id_next;
            held_ext_reg <= held_ext_next;
            exp_len_reg  <= exp_len_next;
            next_seq_reg <= next_seq_next;
            fill_reg     <= fill_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            f_id_reg   <= s_tdata[ID_W-1:0];
            f_dlc_reg  <= s_tdata[ID_W +: DLC_W];
            f_data_reg <= s_tdata[ID_W + DLC_W +: DATA_W];
            f_ext_reg  <= s_tuser;
        end
        emit_id_reg  <= emit_id_next;
        emit_ext_reg <= emit_ext_next;
        emit_len_reg <= emit_len_next;
        row_reg      <= row_next;
        if (load_out) begin
            o_id_reg   <= emit_id_reg;
            o_ext_reg  <= emit_ext_reg;
            o_len_reg  <= emit_len_reg;
            o_data_reg <= chunk;
            o_cnt_reg  <= out_cnt;
            o_last_reg <= out_last;
        end
    end

    // byte lanes of the payload store
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        itp_lane u_lane (
            .aclk       (aclk),
            .lane_idx   (LANE_W'(g)),
            .wr         (wr),
            .frame_data (f_data_reg),
            .rd_row     (row_reg),
            .rd_byte    (lane_bytes[g])
        );
    end

    // chunk assembly
    itp_merge u_merge (
        .sel_frame  (state_reg == ST_SF),
        .frame_data (f_data_reg),
        .lane_bytes (lane_bytes),
        .count      (out_cnt),
        .chunk_data (chunk)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_ext_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = M_TDATA_W'({o_cnt_reg, o_data_reg, o_len_reg, o_id_reg});

endmodule

`default_nettype wire

// ----- rtl/core/itp_checker.sv -----
// port-level checks on the reassembler input and result streams, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module itp_checker
    import itp_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser,
    input wire logic                 m_tlast
);

    localparam int LEN_LO = ID_W;
    localparam int CNT_LO = ID_W + LEN_W + DATA_W;

    logic [CNT_W-1:0] chunk_bytes;
    logic [LEN_W-1:0] total_length;

    assign chunk_bytes  = m_tdata[CNT_LO +: CNT_W];
    assign total_length = m_tdata[LEN_LO +: LEN_W];

    // one input transaction at a time, the next waits for the decode
    a_one_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a frame is in progress");

    // a stalled chunk holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled chunk changed");

    // nothing is offered right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // every chunk but the last is full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> chunk_bytes == CNT_W'(LANES))
        else $error("short chunk before end of message");

    // a last chunk is empty only for an empty message
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (chunk_bytes != '0 || total_length == '0)
            && chunk_bytes <= CNT_W'(LANES))
        else $error("bad final chunk size");

endmodule

bind isotp_reassembler_core itp_checker u_itp_checker (.*);

`default_nettype wire
